### hw/rtl/sawsr_pkg.sv
package sawsr_pkg;

    localparam int unsigned SEQ_W    = 8;
    localparam int unsigned CNT_W    = 4;
    localparam int unsigned TICK_W   = 16;
    localparam int unsigned LEN_W    = 7;
    localparam int unsigned IN_W     = 24;
    localparam int unsigned OUT_W    = 16;
    localparam int unsigned ADDR_W   = 4;
    localparam int unsigned DATA_W   = 32;

    localparam logic [1:0] REG_SEND_GAP      = 2'd0;
    localparam logic [1:0] REG_RETRY_GAP     = 2'd1;
    localparam logic [1:0] REG_RETRY_LIMIT   = 2'd2;
    localparam logic [1:0] REG_ACK_FRAME_LEN = 2'd3;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

    localparam logic [TICK_W-1:0] SEND_GAP_RST      = 16'd5;
    localparam logic [TICK_W-1:0] RETRY_GAP_RST     = 16'd2;
    localparam logic [CNT_W-1:0]  RETRY_LIMIT_RST   = 4'd3;
    localparam logic [LEN_W-1:0]  ACK_FRAME_LEN_RST = 7'd57;

    typedef struct packed {
        logic [TICK_W-1:0] send_gap;
        logic [TICK_W-1:0] retry_gap;
        logic [CNT_W-1:0]  retry_limit;
        logic [LEN_W-1:0]  ack_frame_length;
    } t_cfg;

    typedef struct packed {
        logic             cmd;
        logic [LEN_W-1:0] rx_length;
        logic [SEQ_W-1:0] rx_ack_byte;
        logic [SEQ_W-1:0] rx_seq;
    } t_item;

    typedef struct packed {
        logic             valid;
        logic             to_relay;
        logic [SEQ_W-1:0] seq_out;
        logic [CNT_W-1:0] attempt;
    } t_res;

endpackage

### hw/rtl/stop_and_wait_sender_relay_fallback_unit.sv
// Channel   Direction  Contents
// s_axis    in         tuser: cmd; tdata: rx_length, rx_ack_byte, rx_seq
// m_axis    out        tuser: to_relay; tdata: seq_out, attempt
// apb       in/out     four registers at byte addresses 0, 4, 8, 12
//
// One event per cycle while the result side is ready: each event passes the
// input register, then one step of the sequencer logic, then the result
// register.
// Reset is synchronous and active low; registers return to 5, 2, 3, 57.
// A stalled result holds the result register and blocks the sequencer step;
// the input register takes one more transfer if empty, then the input stalls
// until the result leaves, also for events that produce no result.
module stop_and_wait_sender_relay_fallback_unit
    import sawsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  logic [IN_W-1:0]   i_s_tdata,   // rx_length[6:0], rx_ack_byte[14:7], rx_seq[22:15]
    input  logic              i_s_tuser,   // cmd[0]
    output logic              o_m_tvalid,
    input  logic              i_m_tready,
    output logic [OUT_W-1:0]  o_m_tdata,   // seq_out[7:0], attempt[11:8]
    output logic              o_m_tuser,   // to_relay[0]
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    t_cfg  w_cfg;
    t_res  w_res;
    t_item r_item;
    logic  r_in_valid;
    t_res  r_out;
    logic  w_step;

    assign w_step     = r_in_valid && (!r_out.valid || i_m_tready);
    assign o_s_tready = !r_in_valid || w_step;

    sawsr_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sawsr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_step),
        .i_item  (r_item),
        .i_cfg   (w_cfg),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_item.cmd         <= i_s_tuser;
            r_item.rx_length   <= i_s_tdata[6:0];
            r_item.rx_ack_byte <= i_s_tdata[14:7];
            r_item.rx_seq      <= i_s_tdata[22:15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out.valid <= 1'b0;
        end else if (w_step) begin
            r_out.valid <= w_res.valid;
        end else if (i_m_tready) begin
            r_out.valid <= 1'b0;
        end
        if (w_step && w_res.valid) begin
            r_out.to_relay <= w_res.to_relay;
            r_out.seq_out  <= w_res.seq_out;
            r_out.attempt  <= w_res.attempt;
        end
    end

    assign o_m_tvalid = r_out.valid;
    assign o_m_tuser  = r_out.to_relay;
    assign o_m_tdata  = {{(OUT_W-SEQ_W-CNT_W){1'b0}}, r_out.attempt, r_out.seq_out};

endmodule

### hw/rtl/sawsr_cfg.sv
module sawsr_cfg
    import sawsr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.send_gap         <= SEND_GAP_RST;
            r_cfg.retry_gap        <= RETRY_GAP_RST;
            r_cfg.retry_limit      <= RETRY_LIMIT_RST;
            r_cfg.ack_frame_length <= ACK_FRAME_LEN_RST;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_SEND_GAP:      r_cfg.send_gap         <= pwdata[TICK_W-1:0];
                REG_RETRY_GAP:     r_cfg.retry_gap        <= pwdata[TICK_W-1:0];
                REG_RETRY_LIMIT:   r_cfg.retry_limit      <= pwdata[CNT_W-1:0];
                REG_ACK_FRAME_LEN: r_cfg.ack_frame_length <= pwdata[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_SEND_GAP:      prdata = {{(DATA_W-TICK_W){1'b0}}, r_cfg.send_gap};
            REG_RETRY_GAP:     prdata = {{(DATA_W-TICK_W){1'b0}}, r_cfg.retry_gap};
            REG_RETRY_LIMIT:   prdata = {{(DATA_W-CNT_W){1'b0}}, r_cfg.retry_limit};
            REG_ACK_FRAME_LEN: prdata = {{(DATA_W-LEN_W){1'b0}}, r_cfg.ack_frame_length};
            default:           prdata = '0;
        endcase
    end

endmodule

### hw/rtl/sawsr_engine.sv
module sawsr_engine
    import sawsr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_fire,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic              r_waiting;
    logic [TICK_W-1:0] r_tick;
    logic [CNT_W-1:0]  r_sends;
    logic [SEQ_W-1:0]  r_seq;
    logic              r_ack;

    logic              n_waiting;
    logic [TICK_W-1:0] n_tick;
    logic [CNT_W-1:0]  n_sends;
    logic [SEQ_W-1:0]  n_seq;
    logic              n_ack;

    logic [TICK_W-1:0] w_tick_inc;
    logic [TICK_W-1:0] w_limit;
    logic [CNT_W-1:0]  w_sends_e;
    logic [SEQ_W-1:0]  w_seq_e;
    logic              w_ack_e;

    always_comb begin
        n_waiting  = r_waiting;
        n_tick     = r_tick;
        n_sends    = r_sends;
        n_seq      = r_seq;
        n_ack      = r_ack;
        o_res      = '0;
        w_tick_inc = r_tick + TICK_W'(1);
        w_limit    = r_waiting ? i_cfg.retry_gap : i_cfg.send_gap;
        w_sends_e  = r_waiting ? r_sends : '0;
        w_ack_e    = r_waiting ? r_ack : 1'b0;
        w_seq_e    = r_waiting ? r_seq : r_seq + SEQ_W'(1);

        if (i_item.cmd == CMD_FRAME) begin
            if (i_item.rx_length == i_cfg.ack_frame_length && i_item.rx_ack_byte != '0 &&
                i_item.rx_seq == r_seq) begin
                n_ack = 1'b1;
            end
        end else if (w_tick_inc < w_limit) begin
            n_tick = w_tick_inc;
        end else begin
            n_tick = '0;
            n_seq  = w_seq_e;
            n_ack  = w_ack_e;
            o_res.seq_out = w_seq_e;
            if (!w_ack_e && w_sends_e < i_cfg.retry_limit) begin
                n_sends        = w_sends_e + CNT_W'(1);
                n_waiting      = 1'b1;
                o_res.valid    = 1'b1;
                o_res.to_relay = 1'b0;
                o_res.attempt  = w_sends_e + CNT_W'(1);
            end else begin
                n_sends        = w_sends_e;
                n_waiting      = 1'b0;
                o_res.valid    = !w_ack_e;
                o_res.to_relay = 1'b1;
                o_res.attempt  = '0;
            end
        end
        o_res.valid = o_res.valid && i_fire;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting <= 1'b0;
            r_tick    <= '0;
            r_sends   <= '0;
            r_seq     <= '0;
            r_ack     <= 1'b0;
        end else if (i_fire) begin
            r_waiting <= n_waiting;
            r_tick    <= n_tick;
            r_sends   <= n_sends;
            r_seq     <= n_seq;
            r_ack     <= n_ack;
        end
    end

endmodule
